### sv/hao_pkg.sv
// shared types, constants and table functions for the harmonic additive oscillator
`default_nettype none

package hao_pkg;

   // default build-time values
   localparam int HARMONICS_DEF        = 16;
   localparam int SAMPLE_RATE_DEF      = 48000;
   localparam int SINE_TABLE_DEPTH_DEF = 1024;
   localparam int PHASE_BITS_DEF       = 32;

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int NOTE_W   = 7;
   localparam int HIDX_W   = 4;
   localparam int GAIN_W   = 16;
   localparam int SAMPLE_W = 20;
   localparam int MAG_W    = 16;
   localparam int PROD_W   = 32;
   localparam int NOTES    = 128;

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd2;
   localparam logic [CMD_W-1:0] CMD_GAIN     = 2'd3;

   // sine polynomial coefficients, Q30
   localparam logic [63:0] SIN_C1  = 64'd1686629713;
   localparam logic [63:0] SIN_C3  = 64'd693598669;
   localparam logic [63:0] SIN_C5  = 64'd85569306;
   localparam logic [63:0] SIN_C7  = 64'd5026995;
   localparam logic [63:0] SIN_C9  = 64'd172272;
   localparam logic [63:0] SIN_C11 = 64'd3864;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [NOTE_W-1:0] note;
      logic [HIDX_W-1:0] harmonic_index;
      logic [GAIN_W-1:0] amplitude;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       sounding;
   } rsp_type;

   // control broadcast to every cell of the ring
   typedef struct packed {
      logic              shift;
      logic              clear;
      logic              gain_we;
      logic [HIDX_W-1:0] gain_index;
      logic [GAIN_W-1:0] gain_data;
   } cell_ctl_type;

   // top octave note frequencies, Hz with 16 fractional bits
   function automatic logic [63:0] top_octave(input int semi);
      logic [63:0] f;
      case (semi)
         0:       f = 64'd548668578;
         1:       f = 64'd581294109;
         2:       f = 64'd615859655;
         3:       f = 64'd652480576;
         4:       f = 64'd691279090;
         5:       f = 64'd732384684;
         6:       f = 64'd775934544;
         7:       f = 64'd822074013;
         8:       f = 64'd870957077;
         9:       f = 64'd922746880;
         10:      f = 64'd977616265;
         default: f = 64'd1035748353;
      endcase
      return f;
   endfunction

   // quarter-wave entry j for a quarter of 2^qbits points, unsigned Q15
   function automatic logic [MAG_W-1:0] sine_entry(input int j, input int qbits);
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] r;
      logic [63:0] v;
      t  = 64'(j) << (30 - qbits);
      t2 = (t * t) >> 30;
      r  = SIN_C9 - ((t2 * SIN_C11) >> 30);
      r  = SIN_C7 - ((t2 * r) >> 30);
      r  = SIN_C5 - ((t2 * r) >> 30);
      r  = SIN_C3 - ((t2 * r) >> 30);
      r  = SIN_C1 - ((t2 * r) >> 30);
      v  = (((t * r) >> 30) + 64'd16384) >> 15;
      return v[MAG_W-1:0];
   endfunction

endpackage

`default_nettype wire

### sv/hao_cell.sv
// one ring cell: holds the phase and gain of one harmonic slot
`default_nettype none

module hao_cell #(
   parameter int PHASE_BITS = hao_pkg::PHASE_BITS_DEF,
   parameter int INDEX      = 0
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire hao_pkg::cell_ctl_type      ctl,
   input  wire logic [PHASE_BITS-1:0]      phase_in,
   input  wire logic [hao_pkg::GAIN_W-1:0] gain_in,
   output logic      [PHASE_BITS-1:0]      phase_out,
   output logic      [hao_pkg::GAIN_W-1:0] gain_out
);

   localparam logic [31:0] SLOT = 32'(INDEX);

   logic [PHASE_BITS-1:0]      phase_ff;
   logic [hao_pkg::GAIN_W-1:0] gain_ff;
   logic                       hit;

   // gain write addressed to this slot
   assign hit = ctl.gain_we && (32'(ctl.gain_index) == SLOT);

   // phase: cleared on note on, rotated during a tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (ctl.clear) begin
         phase_ff <= '0;
      end else if (ctl.shift) begin
         phase_ff <= phase_in;
      end
   end

   // gain: written by index while idle, rotated during a tick
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
      end else if (hit) begin
         gain_ff <= ctl.gain_data;
      end else if (ctl.shift) begin
         gain_ff <= gain_in;
      end
   end

   assign phase_out = phase_ff;
   assign gain_out  = gain_ff;

endmodule

`default_nettype wire

### sv/hao_head.sv
// ring head: sine lookup, gain multiply, accumulate and phase advance
`default_nettype none

module hao_head #(
   parameter int HARMONICS        = hao_pkg::HARMONICS_DEF,
   parameter int SINE_TABLE_DEPTH = hao_pkg::SINE_TABLE_DEPTH_DEF,
   parameter int PHASE_BITS       = hao_pkg::PHASE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                issue,
   input  wire logic        [PHASE_BITS-1:0]        step,
   input  wire logic        [PHASE_BITS-1:0]        phase,
   input  wire logic        [hao_pkg::GAIN_W-1:0]   gain,
   output logic             [PHASE_BITS-1:0]        phase_next,
   output logic                                     busy,
   output logic signed      [hao_pkg::SAMPLE_W-1:0] sample
);

   localparam int DEPTH_BITS = $clog2(SINE_TABLE_DEPTH);
   localparam int QB         = DEPTH_BITS - 2;
   localparam int QUARTER    = SINE_TABLE_DEPTH / 4;
   localparam int ACC_W      = hao_pkg::PROD_W + $clog2(HARMONICS) + 1;
   localparam int RND_W      = ACC_W + 1;
   localparam logic signed [RND_W-1:0] HALF    = RND_W'(32768);
   localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'(524287);
   localparam logic signed [RND_W-1:0] SAT_MIN = -RND_W'(524288);

   logic [hao_pkg::MAG_W-1:0] tab [QUARTER+1];

   logic [1:0]                       quad;
   logic [QB-1:0]                    off;
   logic [QB:0]                      addr;
   logic [PHASE_BITS-1:0]            inc_ff;
   logic [hao_pkg::MAG_W-1:0]        mag_ff;
   logic                             neg_ff;
   logic [hao_pkg::GAIN_W-1:0]       gain_ff;
   logic                             s1_v_ff;
   logic                             s2_v_ff;
   logic [hao_pkg::PROD_W-1:0]       mag_prod;
   logic signed [hao_pkg::PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]          acc_ff;
   logic signed [RND_W-1:0]          biased;
   logic signed [RND_W-1:0]          rounded;

   // quarter-wave table, built at elaboration
   for (genvar j = 0; j <= QUARTER; j++) begin : g_tab
      assign tab[j] = hao_pkg::sine_entry(j, QB);
   end

   // point index from the top phase bits; odd quadrants read mirrored
   assign quad = phase[PHASE_BITS-1 -: 2];
   assign off  = phase[PHASE_BITS-3 -: QB];
   assign addr = quad[0] ? ((QB+1)'(QUARTER) - {1'b0, off}) : {1'b0, off};

   // running partial step: (k+1) times the fundamental for slot k
   always_ff @(posedge clock) begin
      if (start) begin
         inc_ff <= step;
      end else if (issue) begin
         inc_ff <= inc_ff + step;
      end
   end

   assign phase_next = phase + inc_ff;

   // stage 1: table read
   always_ff @(posedge clock) begin
      mag_ff  <= tab[addr];
      neg_ff  <= quad[1];
      gain_ff <= gain;
   end

   // stage 2: signed product
   assign mag_prod = hao_pkg::PROD_W'(mag_ff) * hao_pkg::PROD_W'(gain_ff);

   always_ff @(posedge clock) begin
      prod_ff <= neg_ff ? -signed'(mag_prod) : signed'(mag_prod);
   end

   // stage 3: accumulate
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
      end else if (s2_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= issue;
         s2_v_ff <= s1_v_ff;
      end
   end

   assign busy = s1_v_ff | s2_v_ff;

   // round half up to 15 fractional bits and saturate
   assign biased  = RND_W'(acc_ff) + HALF;
   assign rounded = biased >>> 16;

   always_comb begin
      if (rounded > SAT_MAX) begin
         sample = hao_pkg::SAMPLE_W'(SAT_MAX);
      end else if (rounded < SAT_MIN) begin
         sample = hao_pkg::SAMPLE_W'(SAT_MIN);
      end else begin
         sample = rounded[hao_pkg::SAMPLE_W-1:0];
      end
   end

endmodule

`default_nettype wire

### sv/harmonic_additive_oscillator_unit.sv
// top level of the harmonic additive oscillator: command decode, sequencer and cell ring
//
// Commands arrive as beats on req_ (valid/ready): sample tick, note on, note off
// and harmonic gain write. Only a tick produces a result beat on rsp_ (valid/ready)
// carrying the summed sample and the sounding flag.
// Note on, note off and gain writes give no result and leave req_ready high;
// the next command can follow in the very next cycle.
// A tick while sounding rotates the ring of HARMONICS cells once past the head,
// one harmonic per cycle, through a three-stage lookup/multiply/accumulate path.
// rsp_valid and req_ready both rise once the rotation has run, the head has drained
// and the sample is loaded, so a sounding tick is taken only after the last is done.
// A tick while silent goes straight to the finishing state, which raises rsp_valid
// and req_ready together, so a silent tick is likewise done before the next is taken.
// The result sits in an output register; req_ready returns once the sample is
// loaded there, so the next command is taken while the result still waits.
// A tick finishing while that register is still full holds until rsp_ready.
// Reset clears all phases, gains, the fundamental step and the sounding flag;
// no clearing pass is needed afterwards.
`default_nettype none

module harmonic_additive_oscillator_unit #(
   parameter int HARMONICS        = hao_pkg::HARMONICS_DEF,
   parameter int SAMPLE_RATE      = hao_pkg::SAMPLE_RATE_DEF,
   parameter int SINE_TABLE_DEPTH = hao_pkg::SINE_TABLE_DEPTH_DEF,
   parameter int PHASE_BITS       = hao_pkg::PHASE_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire hao_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output hao_pkg::rsp_type      rsp_data
);

   localparam int CNT_W = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(HARMONICS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FIN
   } state_type;

   state_type                         state_ff;
   logic [CNT_W-1:0]                  cnt_ff;
   logic [PHASE_BITS-1:0]             step_ff;
   logic                              active_ff;
   logic                              rsp_valid_ff;
   hao_pkg::rsp_type                  rsp_data_ff;

   logic [PHASE_BITS-1:0]             step_tab [hao_pkg::NOTES];
   logic                              accept;
   logic                              is_tick;
   hao_pkg::cell_ctl_type             ctl;
   logic [PHASE_BITS-1:0]             ring_phase [HARMONICS];
   logic [hao_pkg::GAIN_W-1:0]        ring_gain  [HARMONICS];
   logic [PHASE_BITS-1:0]             phase_next;
   logic                              head_busy;
   logic signed [hao_pkg::SAMPLE_W-1:0] head_sample;

   // note to phase step table, rounded half up, built at elaboration
   for (genvar n = 0; n < hao_pkg::NOTES; n++) begin : g_note
      localparam int OCT  = n / 12;
      localparam int SEMI = n % 12;
      localparam logic [63:0] NUM  = hao_pkg::top_octave(SEMI) << PHASE_BITS;
      localparam logic [63:0] DEN  = 64'(SAMPLE_RATE) << (26 - OCT);
      localparam logic [63:0] STEP = (NUM + DEN / 2) / DEN;
      assign step_tab[n] = STEP[PHASE_BITS-1:0];
   end

   // command decode
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_tick   = (req_data.cmd == hao_pkg::CMD_TICK);

   // cell control
   always_comb begin
      ctl.shift      = (state_ff == ST_RUN);
      ctl.clear      = accept && (req_data.cmd == hao_pkg::CMD_NOTE_ON);
      ctl.gain_we    = accept && (req_data.cmd == hao_pkg::CMD_GAIN);
      ctl.gain_index = req_data.harmonic_index;
      ctl.gain_data  = req_data.amplitude;
   end

   // ring of cells; the last one takes the advanced phase from the head
   for (genvar i = 0; i < HARMONICS; i++) begin : g_cell
      logic [PHASE_BITS-1:0]      p_in;
      logic [hao_pkg::GAIN_W-1:0] g_in;
      if (i == HARMONICS - 1) begin : g_tail
         assign p_in = phase_next;
         assign g_in = ring_gain[0];
      end else begin : g_mid
         assign p_in = ring_phase[i+1];
         assign g_in = ring_gain[i+1];
      end
      hao_cell #(
         .PHASE_BITS (PHASE_BITS),
         .INDEX      (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .phase_in  (p_in),
         .gain_in   (g_in),
         .phase_out (ring_phase[i]),
         .gain_out  (ring_gain[i])
      );
   end

   hao_head #(
      .HARMONICS        (HARMONICS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .PHASE_BITS       (PHASE_BITS)
   ) u_head (
      .clock      (clock),
      .reset      (reset),
      .start      (accept && is_tick),
      .issue      (state_ff == ST_RUN),
      .step       (step_ff),
      .phase      (ring_phase[0]),
      .gain       (ring_gain[0]),
      .phase_next (phase_next),
      .busy       (head_busy),
      .sample     (head_sample)
   );

   // sequencer, note state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         step_ff      <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (accept) begin
                  case (req_data.cmd)
                     hao_pkg::CMD_NOTE_ON: begin
                        step_ff   <= step_tab[req_data.note];
                        active_ff <= 1'b1;
                     end
                     hao_pkg::CMD_NOTE_OFF: begin
                        step_ff   <= '0;
                        active_ff <= 1'b0;
                     end
                     hao_pkg::CMD_TICK: begin
                        state_ff <= active_ff ? ST_RUN : ST_FIN;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_RUN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!head_busy) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff.sample   <= active_ff ? head_sample : '0;
                  rsp_data_ff.sounding <= active_ff;
                  rsp_valid_ff         <= 1'b1;
                  state_ff             <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a result beat appears only out of the finishing state
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside finishing state");

   // a tick while sounding starts a ring rotation
   a_tick_runs: assert property (@(posedge clock) disable iff (reset)
      (accept && is_tick && active_ff) |=> (state_ff == ST_RUN))
      else $error("sounding tick did not start rotation");

   // the head pipeline is empty whenever a new command can be taken
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !head_busy)
      else $error("head pipeline busy while idle");

   // a silent result carries a zero sample
   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.sounding) |-> (rsp_data_ff.sample == '0))
      else $error("silent result with nonzero sample");

   // rotation counter resets before every run
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_RUN) |-> (cnt_ff == '0))
      else $error("rotation began with stale count");

endmodule

`default_nettype wire
